// File: src/copc_pkg.sv
// Package for the circle overlap pixel colouriser: shared constants, codes,
// the controller state type and the colour palette.
// Depends on nothing; used by the top module, the checker and the testbench.
package copc_pkg;

	localparam int MAX_CENTRES_DEF = 64;
	localparam int COORD_BITS_DEF  = 12;

	localparam int RADIUS_W = 12;
	localparam int R2_W     = 2 * RADIUS_W;
	localparam int CNT_OUT_W = 7;
	localparam int COLOR_W  = 8;
	localparam int SEL_W    = 4;

	localparam logic [RADIUS_W-1:0] RADIUS_RESET = 12'd50;
	localparam logic [R2_W-1:0]     R2_RESET     = 24'(RADIUS_RESET) * 24'(RADIUS_RESET);

	typedef enum logic {
		FUNC_ADD   = 1'b0,
		FUNC_QUERY = 1'b1
	} func_t;

	typedef enum logic [1:0] {
		ST_IDLE,
		ST_WALK,
		ST_DRAIN
	} state_t;

	typedef struct packed {
		logic [COLOR_W-1:0] red;
		logic [COLOR_W-1:0] green;
		logic [COLOR_W-1:0] blue;
	} rgb_t;

	// Palette index is the hit count limited to eight.
	function automatic rgb_t palette(input logic [SEL_W-1:0] sel);
		rgb_t c;
		unique case (sel)
			4'd0, 4'd1: c = '{8'd255, 8'd255, 8'd255};
			4'd2:       c = '{8'd255, 8'd0,   8'd0};
			4'd3:       c = '{8'd255, 8'd165, 8'd0};
			4'd4:       c = '{8'd255, 8'd255, 8'd0};
			4'd5:       c = '{8'd0,   8'd255, 8'd0};
			4'd6:       c = '{8'd0,   8'd0,   8'd255};
			4'd7:       c = '{8'd75,  8'd0,   8'd130};
			default:    c = '{8'd255, 8'd105, 8'd180};
		endcase
		return c;
	endfunction

endpackage

// File: src/copc_store.sv
// Centre store: one synchronous memory holding x and y of each circle centre,
// one write port and one read port with registered read data.
// Depends on nothing; it does not import copc_pkg and uses no shared types.
module copc_store #(
	parameter int MAX_CENTRES = 64,
	parameter int COORD_BITS  = 12,
	parameter int IDX_W       = (MAX_CENTRES > 1) ? $clog2(MAX_CENTRES) : 1
) (
	input  logic                  clk,
	input  logic                  we,
	input  logic [IDX_W-1:0]      waddr,
	input  logic [COORD_BITS-1:0] wx,
	input  logic [COORD_BITS-1:0] wy,
	input  logic                  re,
	input  logic [IDX_W-1:0]      raddr,
	output logic [COORD_BITS-1:0] rx,
	output logic [COORD_BITS-1:0] ry
);

	logic [2*COORD_BITS-1:0] mem [MAX_CENTRES];
	logic [2*COORD_BITS-1:0] rdata_s1;

	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= {wx, wy};
		end
	end

	always_ff @(posedge clk) begin
		if (re) begin
			rdata_s1 <= mem[raddr];
		end
	end

	assign rx = rdata_s1[2*COORD_BITS-1:COORD_BITS];
	assign ry = rdata_s1[COORD_BITS-1:0];

endmodule

// File: src/circle_overlap_pixel_colorizer.sv
// Circle overlap pixel colouriser. An add transaction loads the output register at
// its accepting edge, so adds can follow one per cycle while unstalled. A query makes
// one store read per cycle through a read, square and compare pipeline and loads its
// result once the pipeline is empty and the slot is free; the next item is taken in
// the cycle after at the earliest. Reset clears the centre count, the radius (to 50)
// and all control state; the centre store is not cleared and needs no clearing pass.
module circle_overlap_pixel_colorizer
	import copc_pkg::*;
#(
	parameter int MAX_CENTRES = MAX_CENTRES_DEF,
	parameter int COORD_BITS  = COORD_BITS_DEF
) (
	input  logic                  clk,
	input  logic                  arst_n,
	input  logic                  radius_we,
	input  logic [RADIUS_W-1:0]   radius_wdata,
	input  logic                  in_valid,
	output logic                  in_stall,
	input  logic                  func,
	input  logic [COORD_BITS-1:0] point_x,
	input  logic [COORD_BITS-1:0] point_y,
	output logic                  out_valid,
	input  logic                  out_stall,
	output logic [CNT_OUT_W-1:0]  covered_count,
	output logic [COLOR_W-1:0]    color_red,
	output logic [COLOR_W-1:0]    color_green,
	output logic [COLOR_W-1:0]    color_blue,
	output logic                  add_dropped
);

	localparam int IDX_W = (MAX_CENTRES > 1) ? $clog2(MAX_CENTRES) : 1;
	localparam int CNT_W = $clog2(MAX_CENTRES + 1);
	localparam int SQ_W  = 2 * COORD_BITS;
	localparam int CMP_W = (SQ_W + 1 > R2_W) ? SQ_W + 1 : R2_W;
	localparam int HX_W  = (CNT_W > CNT_OUT_W) ? CNT_W : CNT_OUT_W;
	localparam logic [CNT_W-1:0] CNT_MAX = CNT_W'(MAX_CENTRES);
	localparam logic [HX_W-1:0]  OUT_SAT = HX_W'((1 << CNT_OUT_W) - 1);
	localparam logic [HX_W-1:0]  SEL_SAT = HX_W'(8);

	state_t st_q, st_d;

	logic [RADIUS_W-1:0]   radius_q;
	logic [R2_W-1:0]       r2_q;
	logic [CNT_W-1:0]      count_q;
	logic [CNT_W-1:0]      issue_q;
	logic [CNT_W-1:0]      hits_q;
	logic [COORD_BITS-1:0] px_q, py_q;

	logic                  rd_v_s1;
	logic [COORD_BITS-1:0] rd_x, rd_y;
	logic [COORD_BITS-1:0] dx, dy;
	logic                  v_s2;
	logic [SQ_W-1:0]       sq_x_s2, sq_y_s2;
	logic                  hit;

	logic                  out_valid_q;
	logic [CNT_OUT_W-1:0]  covered_q;
	rgb_t                  color_q;
	logic                  dropped_q;

	logic slot_free, in_acc, is_add, full, mem_we, mem_re;
	logic issue_done, pipe_empty, load_add, load_query, clear_hits;
	logic [HX_W-1:0]       hits_x;
	logic [SEL_W-1:0]      sel;

	assign slot_free  = !out_valid_q || !out_stall;
	assign in_stall   = !((st_q == ST_IDLE) && slot_free);
	assign in_acc     = in_valid && !in_stall;
	assign is_add     = (func_t'(func) == FUNC_ADD);
	assign full       = (count_q == CNT_MAX);
	assign mem_we     = in_acc && is_add && !full;
	assign issue_done = (issue_q == count_q);
	assign mem_re     = (st_q == ST_WALK) && !issue_done;
	assign pipe_empty = !rd_v_s1 && !v_s2;
	assign load_add   = in_acc && is_add;

	always_comb begin
		st_d       = st_q;
		load_query = 1'b0;
		clear_hits = 1'b0;
		unique case (st_q)
			ST_IDLE: begin
				if (in_acc && !is_add) begin
					st_d       = ST_WALK;
					clear_hits = 1'b1;
				end
			end
			ST_WALK: begin
				if (issue_done) begin
					st_d = ST_DRAIN;
				end
			end
			ST_DRAIN: begin
				// The last comparison has landed once both pipeline stages are empty.
				if (pipe_empty && slot_free) begin
					load_query = 1'b1;
					st_d       = ST_IDLE;
				end
			end
			default: st_d = ST_IDLE;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			st_q <= ST_IDLE;
		end else begin
			st_q <= st_d;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			radius_q <= RADIUS_RESET;
			r2_q     <= R2_RESET;
		end else begin
			if (radius_we) begin
				radius_q <= radius_wdata;
			end
			r2_q <= R2_W'(radius_q) * R2_W'(radius_q);
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			count_q <= '0;
		end else if (mem_we) begin
			count_q <= count_q + 1'b1;
		end
	end

	always_ff @(posedge clk) begin
		if (in_acc) begin
			px_q <= point_x;
			py_q <= point_y;
		end
	end

	copc_store #(
		.MAX_CENTRES (MAX_CENTRES),
		.COORD_BITS  (COORD_BITS),
		.IDX_W       (IDX_W)
	) u_store (
		.clk   (clk),
		.we    (mem_we),
		.waddr (count_q[IDX_W-1:0]),
		.wx    (point_x),
		.wy    (point_y),
		.re    (mem_re),
		.raddr (issue_q[IDX_W-1:0]),
		.rx    (rd_x),
		.ry    (rd_y)
	);

	assign dx  = (rd_x >= px_q) ? rd_x - px_q : px_q - rd_x;
	assign dy  = (rd_y >= py_q) ? rd_y - py_q : py_q - rd_y;
	assign hit = (CMP_W'(sq_x_s2) + CMP_W'(sq_y_s2)) < CMP_W'(r2_q);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			issue_q <= '0;
			rd_v_s1 <= 1'b0;
			v_s2    <= 1'b0;
			hits_q  <= '0;
		end else begin
			if (clear_hits) begin
				issue_q <= '0;
			end else if (mem_re) begin
				issue_q <= issue_q + 1'b1;
			end
			rd_v_s1 <= mem_re;
			v_s2    <= rd_v_s1;
			if (clear_hits) begin
				hits_q <= '0;
			end else if (v_s2 && hit) begin
				hits_q <= hits_q + 1'b1;
			end
		end
	end

	always_ff @(posedge clk) begin
		sq_x_s2 <= SQ_W'(dx) * SQ_W'(dx);
		sq_y_s2 <= SQ_W'(dy) * SQ_W'(dy);
	end

	assign hits_x = HX_W'(hits_q);
	assign sel    = (hits_x > SEL_SAT) ? SEL_W'(8) : hits_x[SEL_W-1:0];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (load_add || load_query) begin
			out_valid_q <= 1'b1;
		end else if (!out_stall) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (load_add) begin
			covered_q <= '0;
			color_q   <= '0;
			dropped_q <= full;
		end else if (load_query) begin
			covered_q <= (hits_x > OUT_SAT) ? OUT_SAT[CNT_OUT_W-1:0] : hits_x[CNT_OUT_W-1:0];
			color_q   <= palette(sel);
			dropped_q <= 1'b0;
		end
	end

	assign out_valid     = out_valid_q;
	assign covered_count = covered_q;
	assign color_red     = color_q.red;
	assign color_green   = color_q.green;
	assign color_blue    = color_q.blue;
	assign add_dropped   = dropped_q;

`ifndef SYNTH
	a_count_bound: assert property (@(posedge clk) disable iff (!arst_n)
		count_q <= CNT_MAX)
		else $error("centre count exceeds store depth");

	a_hits_bound: assert property (@(posedge clk) disable iff (!arst_n)
		hits_q <= count_q)
		else $error("hit count exceeds stored centres");

	a_add_grows: assert property (@(posedge clk) disable iff (!arst_n)
		(in_acc && is_add && !full) |=> (count_q == $past(count_q) + 1'b1))
		else $error("accepted add did not extend the store");

	a_drop_blank: assert property (@(posedge clk) disable iff (!arst_n)
		(out_valid && add_dropped) |-> (covered_count == '0 && color_red == '0))
		else $error("dropped add transaction carries query data");
`endif

endmodule

// File: verif/circle_overlap_pixel_colorizer_check.sv
// Checker for the circle overlap pixel colouriser: watches the radius port and
// both transaction channels, predicts every result and compares it field by field.
// Depends on copc_pkg; instantiated beside the block by the testbench top.
module circle_overlap_pixel_colorizer_check
	import copc_pkg::*;
(
	input  logic                      clk,
	input  logic                      arst_n,
	input  logic                      radius_we,
	input  logic [RADIUS_W-1:0]       radius_wdata,
	input  logic                      in_valid,
	input  logic                      in_stall,
	input  logic                      func,
	input  logic [COORD_BITS_DEF-1:0] point_x,
	input  logic [COORD_BITS_DEF-1:0] point_y,
	input  logic                      out_valid,
	input  logic                      out_stall,
	input  logic [CNT_OUT_W-1:0]      covered_count,
	input  logic [COLOR_W-1:0]        color_red,
	input  logic [COLOR_W-1:0]        color_green,
	input  logic [COLOR_W-1:0]        color_blue,
	input  logic                      add_dropped,
	output int                        fail_count,
	output int                        outstanding
);

	typedef struct packed {
		logic [CNT_OUT_W-1:0] covered;
		rgb_t                 colour;
		logic                 dropped;
	} pixel_result_t;

	// Colour per hit count, the last entry standing for eight or more.
	localparam logic [3*COLOR_W-1:0] SHADES [9] = '{
		24'hFFFFFF, 24'hFFFFFF, 24'hFF0000, 24'hFFA500, 24'hFFFF00,
		24'h00FF00, 24'h0000FF, 24'h4B0082, 24'hFF69B4
	};

	logic [COORD_BITS_DEF-1:0] centre_x [MAX_CENTRES_DEF];
	logic [COORD_BITS_DEF-1:0] centre_y [MAX_CENTRES_DEF];
	int unsigned               centres = 0;
	logic [RADIUS_W-1:0]       radius_cfg = RADIUS_RESET;
	pixel_result_t             pixel_results_q [$];
	int                        failures = 0;

	function automatic pixel_result_t apply_transaction(input logic op,
			input logic [COORD_BITS_DEF-1:0] x, input logic [COORD_BITS_DEF-1:0] y);
		pixel_result_t   res;
		longint unsigned dx, dy, reach;
		int unsigned     hits, k;
		res = '0;
		if (op == FUNC_ADD) begin
			if (centres < MAX_CENTRES_DEF) begin
				centre_x[centres] = x;
				centre_y[centres] = y;
				centres++;
			end else begin
				res.dropped = 1'b1;
			end
			return res;
		end
		reach = longint'(radius_cfg) * longint'(radius_cfg);
		hits = 0;
		for (k = 0; k < centres; k++) begin
			dx = (x >= centre_x[k]) ? longint'(x - centre_x[k]) : longint'(centre_x[k] - x);
			dy = (y >= centre_y[k]) ? longint'(y - centre_y[k]) : longint'(centre_y[k] - y);
			if (dx * dx + dy * dy < reach)
				hits++;
		end
		res.covered = (hits > 127) ? 7'd127 : hits[CNT_OUT_W-1:0];
		res.colour = rgb_t'(SHADES[(hits > 8) ? 8 : hits]);
		return res;
	endfunction

	function automatic void check_field(input string name, input int unsigned want,
			input int unsigned got);
		if (want != got) begin
			$error("%s: expected %0d, got %0d", name, want, got);
			failures++;
		end
	endfunction

	always @(posedge clk or negedge arst_n) begin
		pixel_result_t want;
		if (!arst_n) begin
			centres = 0;
			radius_cfg = RADIUS_RESET;
			pixel_results_q.delete();
			failures = 0;
			fail_count <= 0;
			outstanding <= 0;
		end else begin
			// The result leaving at this edge always belongs to an earlier transaction,
			// so it is matched before any new one is predicted.
			if (out_valid && !out_stall) begin
				if (pixel_results_q.size() == 0) begin
					$error("result with no transaction waiting for it");
					failures++;
				end else begin
					want = pixel_results_q.pop_front();
					check_field("covered_count", want.covered, covered_count);
					check_field("color_red", want.colour.red, color_red);
					check_field("color_green", want.colour.green, color_green);
					check_field("color_blue", want.colour.blue, color_blue);
					check_field("add_dropped", want.dropped, add_dropped);
				end
			end
			if (radius_we)
				radius_cfg = radius_wdata;
			if (in_valid && !in_stall)
				pixel_results_q.push_back(apply_transaction(func, point_x, point_y));
			fail_count <= failures;
			outstanding <= pixel_results_q.size();
		end
	end

endmodule

// File: verif/circle_overlap_pixel_colorizer_test.sv
// Testbench top for the circle overlap pixel colouriser: clock, reset, radius
// settings and transaction stimulus, with the verdict at the end.
// Depends on copc_pkg, the block and circle_overlap_pixel_colorizer_check.
module circle_overlap_pixel_colorizer_test;
	import copc_pkg::*;

	localparam int COORD_MAX  = (1 << COORD_BITS_DEF) - 1;
	localparam int LIMIT      = 1_000_000;
	localparam int PHASES     = 9;
	localparam int HOLD_PHASE = 3;
	localparam int QUIET_PHASE = 5;
	localparam int HOLD_LEN   = 300;
	localparam int HOTSPOTS   = 4;

	logic                      clk = 1'b0;
	logic                      arst_n;
	logic                      radius_we;
	logic [RADIUS_W-1:0]       radius_wdata;
	logic                      in_valid;
	logic                      in_stall;
	logic                      func;
	logic [COORD_BITS_DEF-1:0] point_x;
	logic [COORD_BITS_DEF-1:0] point_y;
	logic                      out_valid;
	logic                      out_stall;
	logic [CNT_OUT_W-1:0]      covered_count;
	logic [COLOR_W-1:0]        color_red;
	logic [COLOR_W-1:0]        color_green;
	logic [COLOR_W-1:0]        color_blue;
	logic                      add_dropped;
	int                        fail_count;
	int                        outstanding;

	int          phase_no = -1;
	bit          hold_done = 1'b0;
	int          hold_cycles;
	int unsigned cycles = 0;
	int          hot_x [HOTSPOTS];
	int          hot_y [HOTSPOTS];

	// Per phase: radius, number of transactions, share of adds and query scatter.
	int phase_radius [PHASES] = '{60, 4095, 0, 1, 150, 2048, 4094, 0, 50};
	int phase_items  [PHASES] = '{150, 130, 110, 130, 140, 140, 130, 140, 140};
	int phase_adds   [PHASES] = '{45, 10, 10, 10, 15, 10, 10, 15, 10};
	int phase_spread [PHASES] = '{80, 2048, 60, 3, 200, 1500, 2500, 300, 70};

	circle_overlap_pixel_colorizer DUT (.*);
	circle_overlap_pixel_colorizer_check checker_inst (.*);

	always begin
		#5 clk = 1'b1;
		#5 clk = 1'b0;
	end

	always @(posedge clk) begin
		cycles <= cycles + 1;
		if (cycles == LIMIT) begin
			$display("CHECKS FAILED");
			$finish;
		end
	end

	// Result side: random stalls, one long hold-off and one phase without any.
	initial begin
		out_stall <= 1'b0;
		forever begin
			@(posedge clk);
			if (phase_no == HOLD_PHASE && !hold_done) begin
				out_stall <= 1'b1;
				for (hold_cycles = 0; hold_cycles < HOLD_LEN; hold_cycles++)
					@(posedge clk);
				out_stall <= 1'b0;
				hold_done = 1'b1;
			end else begin
				out_stall <= (phase_no != QUIET_PHASE) && ($urandom_range(99) < 16);
			end
		end
	end

	task automatic offer(input logic op, input int x, input int y);
		int gap;
		if (phase_no != QUIET_PHASE && $urandom_range(99) < 16) begin
			in_valid <= 1'b0;
			gap = ($urandom_range(3) == 0) ? $urandom_range(5, 80) : $urandom_range(1, 4);
			repeat (gap) @(posedge clk);
		end
		in_valid <= 1'b1;
		func <= op;
		point_x <= COORD_BITS_DEF'(x);
		point_y <= COORD_BITS_DEF'(y);
		@(posedge clk);
		while (in_stall)
			@(posedge clk);
	endtask

	// Lowers valid in the step of the last acceptance, then waits for every result.
	task automatic drain();
		in_valid <= 1'b0;
		@(posedge clk);
		while (outstanding != 0)
			@(posedge clk);
	endtask

	task automatic write_radius(input int value);
		drain();
		radius_we <= 1'b1;
		radius_wdata <= RADIUS_W'(value);
		@(posedge clk);
		radius_we <= 1'b0;
	endtask

	// Most points fall near one of a few hotspots so that circles overlap deeply.
	task automatic pick_point(input int spread, output int x, output int y);
		int h;
		if ($urandom_range(99) < 70) begin
			h = $urandom_range(HOTSPOTS - 1);
			x = hot_x[h] + int'($urandom_range(2 * spread)) - spread;
			y = hot_y[h] + int'($urandom_range(2 * spread)) - spread;
		end else begin
			x = $urandom_range(COORD_MAX);
			y = $urandom_range(COORD_MAX);
		end
	endtask

	initial begin
		int p, i, x, y;
		logic op;
		arst_n <= 1'b0;
		in_valid <= 1'b0;
		func <= FUNC_ADD;
		point_x <= '0;
		point_y <= '0;
		radius_we <= 1'b0;
		radius_wdata <= '0;
		phase_radius[7] = $urandom_range(COORD_MAX);
		hot_x[0] = 0;
		hot_y[0] = COORD_MAX;
		for (i = 1; i < HOTSPOTS; i++) begin
			hot_x[i] = $urandom_range(COORD_MAX);
			hot_y[i] = $urandom_range(COORD_MAX);
		end
		repeat (3) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// Empty store, then centres on the corners and on the radius boundary at reset radius.
		offer(FUNC_QUERY, 0, 0);
		offer(FUNC_ADD, 0, 0);
		offer(FUNC_ADD, COORD_MAX, COORD_MAX);
		offer(FUNC_ADD, 49, 0);
		offer(FUNC_ADD, 50, 0);
		offer(FUNC_ADD, 30, 40);
		offer(FUNC_QUERY, 0, 0);
		offer(FUNC_QUERY, 50, 0);
		offer(FUNC_QUERY, COORD_MAX, COORD_MAX);
		offer(FUNC_QUERY, COORD_MAX, 0);
		// A zero radius covers nothing, even a pixel on a centre.
		write_radius(0);
		offer(FUNC_QUERY, 0, 0);
		offer(FUNC_QUERY, 49, 0);
		// The widest radius reaches most of the plane; three more centres bring the count to eight.
		write_radius(COORD_MAX);
		offer(FUNC_QUERY, 2048, 2048);
		offer(FUNC_QUERY, 0, COORD_MAX);
		offer(FUNC_ADD, 2000, 2000);
		offer(FUNC_ADD, 2000, 2000);
		offer(FUNC_ADD, 2000, 2000);
		offer(FUNC_QUERY, 2000, 2000);
		offer(FUNC_QUERY, COORD_MAX, COORD_MAX);

		// The store fills in the first phase; later adds are mostly refused.
		for (p = 0; p < PHASES; p++) begin
			write_radius(phase_radius[p]);
			phase_no = p;
			for (i = 0; i < phase_items[p]; i++) begin
				op = ($urandom_range(99) < phase_adds[p]) ? FUNC_ADD : FUNC_QUERY;
				pick_point((op == FUNC_ADD) ? 40 : phase_spread[p], x, y);
				offer(op, x, y);
			end
		end

		drain();
		repeat (8) @(posedge clk);
		if (fail_count == 0)
			$display("ALL CHECKS PASSED");
		else
			$display("CHECKS FAILED");
		$finish;
	end

endmodule

// File: files.f
src/copc_pkg.sv
src/copc_store.sv
src/circle_overlap_pixel_colorizer.sv
verif/circle_overlap_pixel_colorizer_check.sv
verif/circle_overlap_pixel_colorizer_test.sv
